FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the region map rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked outside reset
`define RMFF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define RMFF_NEVER(label, expr, msg) \
    `RMFF_ASSERT(label, !(expr), msg)

`endif

FILE: sv/rmff_pkg.sv
// ----------------------------------------------------------------------------
// rmff_pkg
// shared types and codes of the first-fit region map: command and result
// transaction layouts, opcodes, status codes and controller states
// ----------------------------------------------------------------------------
package rmff_pkg;

    localparam logic       OP_INSERT   = 1'b0;
    localparam logic       OP_LOOKUP   = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFIT  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    localparam logic [1:0] KIND_UNDEF  = 2'd0;

    typedef struct packed {
        logic        opcode;
        logic [31:0] region_size;
        logic [1:0]  region_kind;
        logic [15:0] region_handle;
        logic [31:0] fault_address;
        logic [31:0] fault_length;
        logic [31:0] fault_base;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] placed_offset;
        logic [15:0] found_handle;
        logic [1:0]  found_kind;
        logic [31:0] adjusted_address;
        logic [31:0] adjusted_length;
        logic [31:0] adjusted_base;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_TAIL,
        ST_PLACE,
        ST_ADJ
    } t_state;

endpackage

FILE: sv/region_map_first_fit_lookup_core.sv
// ----------------------------------------------------------------------------
// region_map_first_fit_lookup_core
// first-fit address range map: keeps mapped regions sorted by offset, places
// new regions in the first gap that fits and resolves fault addresses
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; its one
// result shows on o_result for a single cycle with o_done high and cannot be
// held off, so capture it when o_done is seen. Entries live in one memory
// read one entry per cycle: an insert into a full table answers in the cycle
// after it is taken, an insert that finds room scans up to the gap, shifts
// the entries above it up one place and writes the new one, an insert with
// no room scans all entries and then checks the tail, and a lookup scans
// until it finds the entry, passes the fault address or runs out of entries.
// busy stays high until the result cycle, in which the next command may
// already be taken. space_size is written through the cfg channel, which is
// ready whenever busy is low. No clearing pass is needed after reset: only
// entries below the count are read.
`include "assert_macros.svh"

module region_map_first_fit_lookup_core #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  rmff_pkg::t_cmd    i_cmd,
    // result strobe
    output logic             o_done,
    output rmff_pkg::t_result o_result,
    // space_size register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [31:0]      i_cfg_data
);

    import rmff_pkg::*;

    localparam int AW    = ADDR_WIDTH;
    localparam int IW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int EW    = 2 * AW + 18;

    // one stored region
    typedef struct packed {
        logic [AW-1:0] offset;
        logic [AW-1:0] size;
        logic [1:0]    kind;
        logic [15:0]   handle;
    } t_entry;

    // control and payload registers
    t_state        r_state,   n_state;
    logic [CW-1:0] r_cnt,     n_cnt;
    logic [CW-1:0] r_pos,     n_pos;     // entry under test, later the gap
    logic [CW-1:0] r_src,     n_src;     // entry being moved up
    logic [AW-1:0] r_begin,   n_begin;   // candidate offset
    logic          r_bover,   n_bover;   // candidate ran past the address space
    logic [AW-1:0] r_space,   n_space;
    t_cmd          r_item,    n_item;
    logic          r_done,    n_done;
    t_result       r_res,     n_res;

    // entry memory ports
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_entry        rd_ent;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    // datapath
    logic [AW-1:0] w_size;
    logic [AW-1:0] w_ptr;
    logic [AW-1:0] w_len;
    logic [AW-1:0] w_base;
    logic [AW:0]   w_ent_end;   // offset + size of the entry read, no wrap
    logic [AW:0]   w_need_end;  // candidate + new size, no wrap
    logic          w_skip;      // new region would overlap the entry read
    logic          w_fits;      // new region ends within the space
    logic          w_last;      // entry under test is the last stored one
    logic [AW-1:0] w_alen;
    logic [AW-1:0] w_alen_cl;
    logic [CW-1:0] pos_p1;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] src_p1;
    logic [CW-1:0] src_m1;

    rmff_entry_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_REGIONS),
        .IDX_W (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_ent)
    );

    // inputs narrowed or widened to the address width
    assign w_size = AW'(r_item.region_size);
    assign w_ptr  = AW'(r_item.fault_address);
    assign w_len  = AW'(r_item.fault_length);
    assign w_base = AW'(r_item.fault_base);

    // full precision sums for the fit and containment checks
    assign w_ent_end  = {1'b0, rd_ent.offset} + {1'b0, rd_ent.size};
    assign w_need_end = {1'b0, r_begin} + {1'b0, w_size};
    assign w_skip     = r_bover || (w_need_end > {1'b0, rd_ent.offset});
    assign w_fits     = !r_bover && !(w_need_end > {1'b0, r_space});

    assign pos_p1 = r_pos + CW'(1);
    assign cnt_m1 = r_cnt - CW'(1);
    assign src_p1 = r_src + CW'(1);
    assign src_m1 = r_src - CW'(1);
    assign w_last = (pos_p1 == r_cnt);

    // lookup adjustment, length clamped to the region size
    assign w_alen    = w_len - rd_ent.offset;
    assign w_alen_cl = (w_alen > rd_ent.size) ? rd_ent.size : w_alen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_space <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_space <= n_space;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_src   <= n_src;
        r_begin <= n_begin;
        r_bover <= n_bover;
        r_item  <= n_item;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_src   = r_src;
        n_begin = r_begin;
        n_bover = r_bover;
        n_space = r_space;
        n_item  = r_item;
        n_done  = 1'b0;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;

        // register write, only taken while idle
        if (i_cfg_valid && o_cfg_ready) begin
            n_space = AW'(i_cfg_data);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item  = i_cmd;
                    n_pos   = '0;
                    n_begin = '0;
                    n_bover = 1'b0;
                    if (i_cmd.opcode == OP_INSERT && r_cnt == CW'(MAX_REGIONS)) begin
                        // full table wins over the fit test
                        n_res        = '0;
                        n_res.status = STAT_FULL;
                        n_done       = 1'b1;
                    end else if (r_cnt == '0) begin
                        if (i_cmd.opcode == OP_INSERT) begin
                            n_state = ST_TAIL;
                        end else begin
                            n_res        = '0;
                            n_res.status = STAT_NOFIT;
                            n_done       = 1'b1;
                        end
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (r_item.opcode == OP_INSERT) begin
                    if (w_skip) begin
                        // move the candidate past this entry
                        n_begin = w_ent_end[AW-1:0];
                        n_bover = w_ent_end[AW];
                        if (w_last) begin
                            n_state = ST_TAIL;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = pos_p1[IW-1:0];
                            n_pos   = pos_p1;
                        end
                    end else begin
                        // gap found before this entry, open it from the top
                        rd_en   = 1'b1;
                        rd_addr = cnt_m1[IW-1:0];
                        n_src   = cnt_m1;
                        n_state = ST_SHIFT;
                    end
                end else begin
                    if (w_ptr < rd_ent.offset) begin
                        n_res        = '0;
                        n_res.status = STAT_NOFIT;
                        n_done       = 1'b1;
                        n_state      = ST_IDLE;
                    end else if (w_ent_end > {1'b0, w_ptr}) begin
                        // hit, read data holds the entry for the adjust step
                        n_state = ST_ADJ;
                    end else if (w_last) begin
                        n_res        = '0;
                        n_res.status = STAT_NOFIT;
                        n_done       = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_p1[IW-1:0];
                        n_pos   = pos_p1;
                    end
                end
            end

            ST_SHIFT: begin
                // write lags the read by one entry, addresses never meet
                wr_en   = 1'b1;
                wr_addr = src_p1[IW-1:0];
                wr_data = rd_ent;
                if (r_src == r_pos) begin
                    n_state = ST_PLACE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = src_m1[IW-1:0];
                    n_src   = src_m1;
                end
            end

            ST_TAIL: begin
                // past the last entry the region must end inside the space
                if (w_fits) begin
                    n_pos   = r_cnt;
                    n_state = ST_PLACE;
                end else begin
                    n_res        = '0;
                    n_res.status = STAT_NOFIT;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            ST_PLACE: begin
                wr_en          = 1'b1;
                wr_addr        = r_pos[IW-1:0];
                wr_data.offset = r_begin;
                wr_data.size   = w_size;
                wr_data.kind   = r_item.region_kind;
                wr_data.handle = r_item.region_handle;
                n_cnt          = r_cnt + CW'(1);
                n_res               = '0;
                n_res.status        = STAT_OK;
                n_res.placed_offset = 32'(r_begin);
                n_done              = 1'b1;
                n_state             = ST_IDLE;
            end

            ST_ADJ: begin
                n_res = '0;
                if (rd_ent.kind == KIND_UNDEF) begin
                    n_res.status = STAT_NOFIT;
                end else begin
                    n_res.status           = STAT_OK;
                    n_res.found_handle     = rd_ent.handle;
                    n_res.found_kind       = rd_ent.kind;
                    n_res.adjusted_address = 32'(w_ptr - rd_ent.offset);
                    n_res.adjusted_length  = 32'(w_alen_cl);
                    n_res.adjusted_base    = 32'(w_base + rd_ent.offset);
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // the table never holds more than its depth
    `RMFF_NEVER(a_cnt_bound, r_cnt > CW'(MAX_REGIONS),
                "entry count past table depth")

    // a successful insert adds exactly one entry
    `RMFF_ASSERT(a_ins_count,
                 o_done && r_item.opcode == OP_INSERT && o_result.status == STAT_OK
                 |-> r_cnt == $past(r_cnt) + CW'(1),
                 "insert did not add one entry")

    // memory writes stay at or below the current count
    `RMFF_NEVER(a_wr_range, wr_en && (CW'(wr_addr) > r_cnt),
                "entry write beyond the table")

    // no result while the table is still being scanned or shifted
    `RMFF_ASSERT(a_no_early, (r_state == ST_SCAN || r_state == ST_SHIFT) |-> !o_done,
                 "result during scan or shift")

endmodule

FILE: sv/rmff_entry_ram.sv
// ----------------------------------------------------------------------------
// rmff_entry_ram
// region entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rmff_entry_ram #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
